// File: rtl/wcts_pkg.sv
// Shared types, codes and constants of the wall column texture stepper.
package wcts_pkg;

  // Field and register widths
  localparam int PD_W       = 16;
  localparam int SH_W       = 12;
  localparam int TH_W       = 11;
  localparam int TW_W       = 11;
  localparam int DIST_W     = 32;
  localparam int SCOL_W     = 12;
  localparam int TCOL_W     = 10;
  localparam int ROW_W      = 12;
  localparam int TEX_W      = 20;
  localparam int ROWCNT_W   = 13;
  localparam int ACC_W      = 32;

  // Stream word layout
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Fixed point and height scaling
  localparam int FRAC_BITS_DEF    = 16;
  localparam int HEIGHT_INT_BITS  = 24;
  localparam int HEIGHT_FACTOR    = 25;
  // 25 * projection_distance fits in this many bits
  localparam int PROD_W           = PD_W + 5;

  // Register reset values
  localparam logic [PD_W-1:0] PD_RST = 16'd1108;
  localparam logic [SH_W-1:0] SH_RST = 12'd1080;
  localparam logic [TH_W-1:0] TH_RST = 11'd64;
  localparam logic [TW_W-1:0] TW_RST = 11'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_DIST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH = 8'd3;

  // Commands carried in in_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDIV,
    ST_SDIV,
    ST_PREP,
    ST_PMUL,
    ST_TMUL
  } state_t;

endpackage

// File: rtl/wall_column_texture_stepper.sv
// Wall column texture stepper: column setup by bit-serial divide and multiply, pixel stepping.
// Start word: the shared radix-2 divider computes the wall height, then the texture step;
//   a setup state follows, and when the top is clipped the shift-add multiplier scales the
//   step by the clipped row count to preload the accumulator; it produces no output word.
// Next word: the shift-add multiplier scales the texture row by texture_width, then the pixel
//   is loaded into the output register; one word is in work at a time.
// Reset (rst_n low, synchronous): configuration registers return to defaults, no span is active.
module wall_column_texture_stepper #(
  parameter int FRAC_BITS = wcts_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: wall_distance[31:0], screen_column[43:32], texture_column[53:44], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wcts_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command
  input  logic                            in_tuser,
  // out_tdata: row[11:0], column[23:12], texel_index[43:24], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wcts_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: draw
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wcts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcts_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int HW  = wcts_pkg::HEIGHT_INT_BITS + FRAC_BITS;
  localparam int NW  = wcts_pkg::PROD_W + 2 * FRAC_BITS;
  localparam int DW  = (HW > 32) ? HW : 32;
  localparam int CW  = $clog2(NW);
  localparam int KW  = wcts_pkg::HEIGHT_INT_BITS;
  localparam int MW  = KW + wcts_pkg::ACC_W;
  localparam int SW  = (wcts_pkg::TH_W + FRAC_BITS > 33) ? wcts_pkg::TH_W + FRAC_BITS : 33;
  localparam int WHW = wcts_pkg::ACC_W - FRAC_BITS;
  localparam int HFW = wcts_pkg::SH_W - 1;

  wcts_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [wcts_pkg::PD_W-1:0] pd_r;
  logic [wcts_pkg::SH_W-1:0] sh_r;
  logic [wcts_pkg::TH_W-1:0] th_r;
  logic [wcts_pkg::TW_W-1:0] tw_r;

  // Column state
  logic [wcts_pkg::ROWCNT_W-1:0] cur_r, end_r;
  logic [wcts_pkg::ACC_W-1:0]    acc_r, step_r;
  logic [wcts_pkg::TCOL_W-1:0]   tcol_r;
  logic [wcts_pkg::SCOL_W-1:0]   scol_r;
  logic [HW-1:0]                 hq_r;

  // Divider
  logic [NW-1:0] dq_r;
  logic [DW-1:0] drem_r, dden_r;
  logic [CW-1:0] dcnt_r;
  logic [DW:0]   d_trial, d_diff;
  logic          d_ge, d_last;
  logic [NW-1:0] d_quo;
  logic [HW-1:0] hq_sat;
  logic [wcts_pkg::ACC_W-1:0] step_sat;

  // Multiplier
  logic [MW-1:0] ma_r, mp_r;
  logic [KW-1:0] mb_r;
  logic          m_done;
  logic [wcts_pkg::ACC_W-1:0] pre_sat;

  // Output register
  logic                           out_valid_r;
  logic [wcts_pkg::ROW_W-1:0]     out_row_r;
  logic [wcts_pkg::SCOL_W-1:0]    out_col_r;
  logic [wcts_pkg::TEX_W-1:0]     out_tex_r;
  logic                           out_draw_r, out_last_r;
  logic                           out_free;

  // Setup and pixel terms
  logic                 in_acc, cmd_start;
  logic [HFW-1:0]       half;
  logic [KW-2:0]        hint2;
  logic [KW-1:0]        hint;
  logic                 first_neg;
  logic [HFW-1:0]       start_row;
  logic [KW-1:0]        kclip;
  logic [KW:0]          last_raw;
  logic [wcts_pkg::ROWCNT_W-1:0] end_calc;
  logic                 active;
  logic [32:0]          acc_sum;
  logic                 acc_upd;
  logic [SW-1:0]        acc_lim;
  logic [WHW-1:0]       whole;

  assign in_acc    = in_tvalid && in_tready;
  assign cmd_start = (in_tuser == wcts_pkg::CMD_START);
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Restoring divide step
  assign d_trial  = {drem_r, dq_r[NW-1]};
  assign d_ge     = d_trial >= {1'b0, dden_r};
  assign d_diff   = d_trial - {1'b0, dden_r};
  assign d_quo    = {dq_r[NW-2:0], d_ge};
  assign d_last   = (dcnt_r == CW'(NW - 1));
  assign hq_sat   = (|d_quo[NW-1:HW]) ? {HW{1'b1}} : d_quo[HW-1:0];
  assign step_sat = (|d_quo[NW-1:32]) ? {32{1'b1}} : d_quo[31:0];

  // Shift-add multiply
  assign m_done  = (mb_r == '0);
  assign pre_sat = (|mp_r[MW-1:32]) ? {32{1'b1}} : mp_r[31:0];

  // First and last rows of the span
  assign half      = sh_r[wcts_pkg::SH_W-1:1];
  assign hint2     = hq_r[HW-1:FRAC_BITS+1];
  assign hint      = hq_r[HW-1:FRAC_BITS];
  assign first_neg = hint2 > (KW-1)'(half);
  assign kclip     = {1'b0, hint2} - KW'(half) + KW'(1);
  assign start_row = first_neg ? '0 : (half - hint2[HFW-1:0]);
  assign last_raw  = {1'b0, hint} + (KW+1)'(start_row);

  always_comb begin
    if (sh_r == '0) begin
      end_calc = '0;
    end else if (last_raw >= (KW+1)'(sh_r)) begin
      end_calc = wcts_pkg::ROWCNT_W'(sh_r - 1'b1);
    end else begin
      end_calc = last_raw[wcts_pkg::ROWCNT_W-1:0];
    end
  end

  // Pixel stepping terms
  assign active  = cur_r < end_r;
  assign whole   = acc_r[wcts_pkg::ACC_W-1:FRAC_BITS];
  assign acc_sum = {1'b0, acc_r} + {1'b0, step_r};
  assign acc_lim = SW'({th_r, {FRAC_BITS{1'b0}}});
  assign acc_upd = !acc_sum[32] && (SW'(acc_sum) < acc_lim);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcts_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_start) state_nxt = wcts_pkg::ST_HDIV;
          else if (active) state_nxt = wcts_pkg::ST_TMUL;
        end
      end
      wcts_pkg::ST_HDIV: if (d_last) state_nxt = wcts_pkg::ST_SDIV;
      wcts_pkg::ST_SDIV: if (d_last) state_nxt = wcts_pkg::ST_PREP;
      wcts_pkg::ST_PREP: state_nxt = first_neg ? wcts_pkg::ST_PMUL : wcts_pkg::ST_IDLE;
      wcts_pkg::ST_PMUL: if (m_done) state_nxt = wcts_pkg::ST_IDLE;
      wcts_pkg::ST_TMUL: if (m_done && out_free) state_nxt = wcts_pkg::ST_IDLE;
      default: state_nxt = wcts_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready = (state_r == wcts_pkg::ST_IDLE);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_tex_r, out_col_r, out_row_r};
  assign out_tuser  = out_draw_r;
  assign out_tlast  = out_last_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wcts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      end_r       <= '0;
      pd_r        <= wcts_pkg::PD_RST;
      sh_r        <= wcts_pkg::SH_RST;
      th_r        <= wcts_pkg::TH_RST;
      tw_r        <= wcts_pkg::TW_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wcts_pkg::REG_PROJ_DIST:  pd_r <= cfg_data[wcts_pkg::PD_W-1:0];
          wcts_pkg::REG_SCR_HEIGHT: sh_r <= cfg_data[wcts_pkg::SH_W-1:0];
          wcts_pkg::REG_TEX_HEIGHT: th_r <= cfg_data[wcts_pkg::TH_W-1:0];
          wcts_pkg::REG_TEX_WIDTH:  tw_r <= cfg_data[wcts_pkg::TW_W-1:0];
          default: ;
        endcase
      end
      // output word leaves, or a new one is loaded
      if (state_r == wcts_pkg::ST_TMUL && m_done && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // span rows
      case (state_r)
        wcts_pkg::ST_PREP: begin
          if (!first_neg) begin
            cur_r <= wcts_pkg::ROWCNT_W'(start_row);
            end_r <= end_calc;
          end
        end
        wcts_pkg::ST_PMUL: begin
          if (m_done) begin
            cur_r <= '0;
            end_r <= end_calc;
          end
        end
        wcts_pkg::ST_TMUL: begin
          if (m_done && out_free) cur_r <= cur_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath: divider, multiplier, column registers, output word
  always_ff @(posedge clk) begin
    case (state_r)
      wcts_pkg::ST_IDLE: begin
        if (in_acc && cmd_start) begin
          // wall height = (25 * pd << 2F) / distance
          scol_r <= in_tdata[43:32];
          tcol_r <= in_tdata[53:44];
          dq_r   <= NW'({wcts_pkg::PROD_W'(wcts_pkg::HEIGHT_FACTOR * pd_r),
                         {(2*FRAC_BITS){1'b0}}});
          drem_r <= '0;
          dden_r <= DW'(in_tdata[31:0]);
          dcnt_r <= '0;
        end else if (in_acc && active) begin
          ma_r <= MW'(whole);
          mb_r <= KW'(tw_r);
          mp_r <= '0;
        end
      end
      wcts_pkg::ST_HDIV: begin
        if (d_last) begin
          // texture step = (texture_height << 2F) / wall height
          hq_r   <= hq_sat;
          dq_r   <= NW'({th_r, {(2*FRAC_BITS){1'b0}}});
          drem_r <= '0;
          dden_r <= DW'(hq_sat);
          dcnt_r <= '0;
        end else begin
          drem_r <= d_ge ? d_diff[DW-1:0] : d_trial[DW-1:0];
          dq_r   <= d_quo;
          dcnt_r <= dcnt_r + 1'b1;
        end
      end
      wcts_pkg::ST_SDIV: begin
        drem_r <= d_ge ? d_diff[DW-1:0] : d_trial[DW-1:0];
        dq_r   <= d_quo;
        dcnt_r <= dcnt_r + 1'b1;
        if (d_last) step_r <= step_sat;
      end
      wcts_pkg::ST_PREP: begin
        acc_r <= '0;
        ma_r  <= MW'(step_r);
        mb_r  <= kclip;
        mp_r  <= '0;
      end
      wcts_pkg::ST_PMUL, wcts_pkg::ST_TMUL: begin
        if (!m_done) begin
          mp_r <= mp_r + (mb_r[0] ? ma_r : '0);
          ma_r <= {ma_r[MW-2:0], 1'b0};
          mb_r <= {1'b0, mb_r[KW-1:1]};
        end else if (state_r == wcts_pkg::ST_PMUL) begin
          // preload for a clipped top
          acc_r <= pre_sat;
        end else if (out_free) begin
          out_row_r  <= cur_r[wcts_pkg::ROW_W-1:0];
          out_col_r  <= scol_r;
          out_tex_r  <= wcts_pkg::TEX_W'(tcol_r) + mp_r[wcts_pkg::TEX_W-1:0];
          out_draw_r <= (cur_r != '0) && (cur_r < wcts_pkg::ROWCNT_W'(sh_r));
          out_last_r <= (cur_r + 1'b1) == end_r;
          if (acc_upd) acc_r <= acc_sum[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/wcts_checker.sv
// Port-level checks of the wall column texture stepper, bound to the top level.
module wcts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wcts_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // a stalled output word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // row zero is never drawn
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && out_tdata[wcts_pkg::ROW_W-1:0] == '0))
    else $error("draw set on row zero");

  // a start word makes no output word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == wcts_pkg::CMD_START && !out_tvalid |=> !out_tvalid)
    else $error("output word after a start word");

  // once a pixel is loaded the block is ready for the next word
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("not ready after pixel load");

endmodule

bind wall_column_texture_stepper wcts_checker u_wcts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
